// ===== rtl/core/bmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bmm_pkg;
   localparam int MAX_VERTICES = 32;
   localparam int MAX_EDGES    = 256;
   localparam int VW = $clog2(MAX_VERTICES);
   localparam int NW = VW + 1;
   localparam int EW = $clog2(MAX_EDGES);
   localparam int ETW = EW + 1;
   localparam int SPW = VW + 1;

   localparam logic [1:0] ST_PAIR   = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_RUN = 1'b1;

   typedef struct packed {
      logic       store_edge;
      logic       start_try;
      logic       fetch_edge;
      logic       scan_step;
      logic       push;
      logic       pop;
      logic       aug_init;
      logic       aug_step;
      logic       next_try;
      logic       emit_step;
      logic       clear_all;
   } ctrl_type;

   typedef struct packed {
      logic reject;
      logic scan_end;
      logic scan_hit;
      logic free_right;
      logic can_push;
      logic stack_last;
      logic aug_done;
      logic tries_done;
      logic emit_valid;
      logic emit_last;
      logic emit_done;
   } stat_type;
endpackage
`default_nettype wire

// ===== rtl/core/bmm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bmm_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [4:0] left_vertex;
   logic [4:0] right_vertex;
   modport source (output valid, cmd, left_vertex, right_vertex, input ready);
   modport sink (input valid, cmd, left_vertex, right_vertex, output ready);
endinterface

interface bmm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [4:0] pair_left;
   logic [4:0] pair_right;
   logic [5:0] match_count;
   logic       last;
   modport source (output valid, status, pair_left, pair_right, match_count, last,
                   input ready);
   modport sink (input valid, status, pair_left, pair_right, match_count, last,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bipartite_max_matching.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bipartite maximum matching. An add beat stores one edge; a bad or overflowing
// edge returns one reject beat, and no input is taken while a result beat waits.
// A run beat performs Kuhn's augmenting path search. Each edge probe passes through
// a wait state for the registered edge RAM read before the scan state, and each
// vertex's frame may scan the whole edge list once per try. An augmenting path is
// then written back one vertex per augment step. Output then steps over the right
// vertices and sends one beat per pair, ending with the last flagged pair or one
// empty beat; output stalls hold it.
module bipartite_max_matching
   import bmm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [5:0] csr_wdata,
   bmm_req_if.sink         req,
   bmm_rsp_if.source       rsp
);
   ctrl_type   ctrl;
   stat_type   stat;
   logic [4:0] out_left, out_right;
   logic [5:0] out_count;

   bmm_datapath u_dp (
      .clock, .reset, .csr_we, .csr_wdata,
      .in_left(req.left_vertex), .in_right(req.right_vertex),
      .ctrl, .stat, .out_left, .out_right, .out_count);

   bmm_ctrl u_ctrl (
      .clock, .reset, .req, .rsp, .stat, .ctrl, .out_left, .out_right, .out_count);

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("beat dropped");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("ready while beat pending");
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == ST_PAIR |-> rsp.match_count != 6'd0)
      else $error("pair with zero count");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/bmm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/bmm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmm_datapath
   import bmm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_we,
   input  wire logic [5:0]    csr_wdata,
   input  wire logic [4:0]    in_left,
   input  wire logic [4:0]    in_right,
   input  wire ctrl_type      ctrl,
   output stat_type           stat,
   output logic [4:0]         out_left,
   output logic [4:0]         out_right,
   output logic [5:0]         out_count
);
   logic [5:0]     cfg_ff;
   logic [NW-1:0]  n;
   logic [ETW-1:0] total_ff;
   logic [MAX_VERTICES-1:0] pvalid_ff;
   logic [VW-1:0]  partner_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] visited_ff;
   logic [VW-1:0]  svert_ff [MAX_VERTICES];
   logic [ETW-1:0] spos_ff  [MAX_VERTICES];
   logic [SPW-1:0] sp_ff;
   logic [ETW-1:0] e_ff;
   logic [VW-1:0]  try_ff;
   logic [NW-1:0]  emit_ff;
   logic [5:0]     found_ff;
   logic [SPW-1:0] k_ff;
   logic [VW-1:0]  el_q, er_q;
   logic [EW-1:0]  rd_addr;
   logic [VW-1:0]  top_v;
   logic [VW-1:0]  w;
   logic           hit;

   always_comb begin
      if (cfg_ff == 6'd0) begin
         n = NW'(1);
      end else if (cfg_ff > 6'(MAX_VERTICES)) begin
         n = NW'(MAX_VERTICES);
      end else begin
         n = NW'(cfg_ff);
      end
   end

   assign rd_addr = ctrl.store_edge ? total_ff[EW-1:0] : e_ff[EW-1:0];

   bmm_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_left_ram (
      .clock(clock), .wr_en(ctrl.store_edge), .wr_addr(total_ff[EW-1:0]),
      .wr_data(in_left), .rd_addr(rd_addr), .rd_data(el_q));
   bmm_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_right_ram (
      .clock(clock), .wr_en(ctrl.store_edge), .wr_addr(total_ff[EW-1:0]),
      .wr_data(in_right), .rd_addr(rd_addr), .rd_data(er_q));

   assign top_v = svert_ff[sp_ff[VW-1:0] - VW'(1)];
   assign w     = partner_ff[er_q];
   assign hit   = (el_q == top_v) && (NW'(el_q) < n) && (NW'(er_q) < n);

   assign stat.reject = (NW'(in_left) >= n) || (NW'(in_right) >= n)
                        || (total_ff >= ETW'(MAX_EDGES));
   assign stat.scan_end    = e_ff >= total_ff;
   assign stat.scan_hit    = hit;
   assign stat.free_right  = !pvalid_ff[er_q];
   assign stat.can_push    = (NW'(w) < n) && !visited_ff[w]
                             && (sp_ff < SPW'(MAX_VERTICES));
   assign stat.stack_last  = sp_ff == SPW'(1);
   assign stat.aug_done    = k_ff == SPW'(0);
   assign stat.tries_done  = NW'(try_ff) + NW'(1) >= n;
   assign stat.emit_valid  = pvalid_ff[emit_ff[VW-1:0]];
   assign stat.emit_last   = ((pvalid_ff >> emit_ff[VW-1:0]) >> 1) == '0;
   assign stat.emit_done   = emit_ff + NW'(1) >= n;

   assign out_left  = partner_ff[emit_ff[VW-1:0]];
   assign out_right = emit_ff[VW-1:0];
   assign out_count = found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= 6'(MAX_VERTICES);
      end else if (csr_we) begin
         cfg_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear_all) begin
         total_ff   <= '0;
         pvalid_ff  <= '0;
         visited_ff <= '0;
         found_ff   <= '0;
         try_ff     <= '0;
         sp_ff      <= '0;
         e_ff       <= '0;
         k_ff       <= '0;
         emit_ff    <= '0;
      end else begin
         if (ctrl.store_edge) begin
            total_ff <= total_ff + ETW'(1);
         end
         if (ctrl.start_try) begin
            visited_ff         <= MAX_VERTICES'(1) << try_ff;
            svert_ff[0]        <= try_ff;
            spos_ff[0]         <= '0;
            sp_ff              <= SPW'(1);
            e_ff               <= '0;
         end
         if (ctrl.fetch_edge) begin
            e_ff <= spos_ff[sp_ff[VW-1:0] - VW'(1)];
         end
         if (ctrl.scan_step) begin
            e_ff <= e_ff + ETW'(1);
            spos_ff[sp_ff[VW-1:0] - VW'(1)] <= e_ff + ETW'(1);
         end
         if (ctrl.push) begin
            spos_ff[sp_ff[VW-1:0] - VW'(1)] <= e_ff;
            visited_ff[w]         <= 1'b1;
            svert_ff[sp_ff[VW-1:0]] <= w;
            spos_ff[sp_ff[VW-1:0]]  <= '0;
            sp_ff                 <= sp_ff + SPW'(1);
            e_ff                  <= '0;
         end
         if (ctrl.pop) begin
            sp_ff <= sp_ff - SPW'(1);
            if (sp_ff > SPW'(1)) begin
               spos_ff[sp_ff[VW-1:0] - VW'(2)] <=
                  spos_ff[sp_ff[VW-1:0] - VW'(2)] + ETW'(1);
            end
         end
         if (ctrl.aug_init) begin
            spos_ff[sp_ff[VW-1:0] - VW'(1)] <= e_ff;
            k_ff  <= sp_ff;
            found_ff <= found_ff + 6'd1;
         end
         if (ctrl.aug_step) begin
            partner_ff[er_q] <= svert_ff[k_ff[VW-1:0] - VW'(1)];
            pvalid_ff[er_q]  <= 1'b1;
            k_ff             <= k_ff - SPW'(1);
            if (k_ff > SPW'(1)) begin
               e_ff <= spos_ff[k_ff[VW-1:0] - VW'(2)];
            end
         end
         if (ctrl.next_try) begin
            try_ff <= try_ff + VW'(1);
         end
         if (ctrl.emit_step) begin
            emit_ff <= emit_ff + NW'(1);
         end
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/bmm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bmm_ctrl
   import bmm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   bmm_req_if.sink       req,
   bmm_rsp_if.source     rsp,
   input  wire stat_type stat,
   output ctrl_type      ctrl,
   input  wire logic [4:0] out_left,
   input  wire logic [4:0] out_right,
   input  wire logic [5:0] out_count
);
   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_TRY   = 10'b0000000010,
      S_FETCH = 10'b0000000100,
      S_WAIT  = 10'b0000001000,
      S_SCAN  = 10'b0000010000,
      S_AUGW  = 10'b0000100000,
      S_AUG   = 10'b0001000000,
      S_EMIT  = 10'b0010000000,
      S_OUT   = 10'b0100000000,
      S_NEXT  = 10'b1000000000
   } state_type;

   state_type  state_ff, state_in;
   logic       rv_ff, rv_in;
   logic [1:0] st_ff, st_in;
   logic [4:0] pl_ff, pl_in, pr_ff, pr_in;
   logic [5:0] mc_ff, mc_in;
   logic       last_ff, last_in;
   logic       acc;

   assign req.ready = (state_ff == S_IDLE) && !rv_ff;
   assign acc = req.valid && req.ready;
   assign rsp.valid = rv_ff;
   assign rsp.status = st_ff;
   assign rsp.pair_left = pl_ff;
   assign rsp.pair_right = pr_ff;
   assign rsp.match_count = mc_ff;
   assign rsp.last = last_ff;

   always_comb begin
      ctrl = '0;
      state_in = state_ff;
      rv_in = rv_ff && !rsp.ready;
      st_in = st_ff; pl_in = pl_ff; pr_in = pr_ff; mc_in = mc_ff;
      last_in = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (req.cmd == CMD_ADD) begin
                  if (stat.reject) begin
                     rv_in = 1'b1; st_in = ST_REJECT; pl_in = '0; pr_in = '0;
                     mc_in = '0; last_in = 1'b0;
                  end else begin
                     ctrl.store_edge = 1'b1;
                  end
               end else begin
                  state_in = S_TRY;
               end
            end
         end
         S_TRY: begin
            ctrl.start_try = 1'b1;
            state_in = S_WAIT;
         end
         S_FETCH: begin
            ctrl.fetch_edge = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.scan_end) begin
               ctrl.pop = 1'b1;
               state_in = stat.stack_last ? S_NEXT : S_FETCH;
            end else if (!stat.scan_hit) begin
               ctrl.scan_step = 1'b1;
               state_in = S_WAIT;
            end else if (stat.free_right) begin
               ctrl.aug_init = 1'b1;
               state_in = S_AUGW;
            end else if (stat.can_push) begin
               ctrl.push = 1'b1;
               state_in = S_WAIT;
            end else begin
               ctrl.scan_step = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_AUGW: begin
            state_in = stat.aug_done ? S_NEXT : S_AUG;
         end
         S_AUG: begin
            ctrl.aug_step = 1'b1;
            state_in = S_AUGW;
         end
         S_NEXT: begin
            if (stat.tries_done) begin
               state_in = S_EMIT;
            end else begin
               ctrl.next_try = 1'b1;
               state_in = S_TRY;
            end
         end
         S_EMIT: begin
            if (stat.emit_valid) begin
               state_in = S_OUT;
            end else if (stat.emit_done) begin
               if (!rv_ff || rsp.ready) begin
                  rv_in = 1'b1; st_in = ST_EMPTY; pl_in = '0; pr_in = '0;
                  mc_in = '0; last_in = 1'b1;
                  ctrl.clear_all = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               ctrl.emit_step = 1'b1;
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp.ready) begin
               rv_in = 1'b1; st_in = ST_PAIR; pl_in = out_left; pr_in = out_right;
               mc_in = out_count; last_in = stat.emit_last;
               if (stat.emit_last) begin
                  ctrl.clear_all = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  ctrl.emit_step = 1'b1;
                  state_in = S_EMIT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in; pl_ff <= pl_in; pr_ff <= pr_in; mc_ff <= mc_in;
      last_ff <= last_in;
   end
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

class match_scoreboard;
   int unsigned n_eff;
   logic [4:0] edge_l[$];
   logic [4:0] edge_r[$];
   int partner[32];
   logic [1:0] exp_status[$];
   logic [4:0] exp_left[$];
   logic [4:0] exp_right[$];
   logic [5:0] exp_count[$];
   logic exp_last[$];
   int errors;

   function new();
      n_eff = 32;
      errors = 0;
      for (int i = 0; i < 32; i++) partner[i] = -1;
   endfunction

   function void set_vertices(logic [5:0] v);
      n_eff = (v == 0) ? 1 : (v > 32 ? 32 : v);
   endfunction

   function void push_exp(logic [1:0] s, logic [4:0] l, logic [4:0] r, logic [5:0] c,
                          logic lst);
      exp_status = {exp_status, s}; exp_left = {exp_left, l}; exp_right = {exp_right, r};
      exp_count = {exp_count, c}; exp_last = {exp_last, lst};
   endfunction

   function bit augment(int start);
      int stk_v[32];
      int stk_e[32];
      bit seen[32];
      int sp, u, e, v, w;
      for (int i = 0; i < 32; i++) seen[i] = 0;
      sp = 1; stk_v[0] = start; stk_e[0] = 0; seen[start] = 1;
      while (sp > 0) begin
         u = stk_v[sp-1];
         e = stk_e[sp-1];
         while (e < edge_l.size() &&
                !(edge_l[e] == u && edge_l[e] < n_eff && edge_r[e] < n_eff)) e++;
         if (e >= edge_l.size()) begin
            sp--;
            if (sp > 0) stk_e[sp-1]++;
            continue;
         end
         stk_e[sp-1] = e;
         v = edge_r[e];
         w = partner[v];
         if (w < 0) begin
            for (int k = sp - 1; k >= 0; k--) partner[edge_r[stk_e[k]]] = stk_v[k];
            return 1;
         end
         if (w >= n_eff || seen[w] || sp >= 32) begin
            stk_e[sp-1] = e + 1;
            continue;
         end
         seen[w] = 1;
         stk_v[sp] = w; stk_e[sp] = 0;
         sp++;
      end
      return 0;
   endfunction

   function void note_input(logic cmd, logic [4:0] l, logic [4:0] r);
      int found, cnt, lastidx;
      if (cmd == bmm_pkg::CMD_ADD) begin
         if (l >= n_eff || r >= n_eff || edge_l.size() >= bmm_pkg::MAX_EDGES)
            push_exp(bmm_pkg::ST_REJECT, 5'd0, 5'd0, 6'd0, 1'b0);
         else begin
            edge_l = {edge_l, l}; edge_r = {edge_r, r};
         end
         return;
      end
      found = 0; cnt = 0;
      for (int i = 0; i < n_eff; i++) if (augment(i)) found++;
      for (int i = 0; i < n_eff; i++) if (partner[i] >= 0) cnt++;
      lastidx = 0;
      for (int i = 0; i < n_eff; i++) begin
         if (partner[i] < 0) continue;
         lastidx++;
         push_exp(bmm_pkg::ST_PAIR, partner[i][4:0], i[4:0], found[5:0], lastidx == cnt);
      end
      if (cnt == 0) push_exp(bmm_pkg::ST_EMPTY, 5'd0, 5'd0, 6'd0, 1'b1);
      edge_l.delete(); edge_r.delete();
      for (int i = 0; i < 32; i++) partner[i] = -1;
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_result(logic [1:0] s, logic [4:0] l, logic [4:0] r,
                     logic [5:0] c, logic lst);
      if (exp_status.size() == 0) begin
         report("unexpected beat");
         return;
      end
      if (s !== exp_status[0]) report($sformatf("status %0d exp %0d", s, exp_status[0]));
      if (l !== exp_left[0]) report($sformatf("pair_left %0d exp %0d", l, exp_left[0]));
      if (r !== exp_right[0]) report($sformatf("pair_right %0d exp %0d", r, exp_right[0]));
      if (c !== exp_count[0]) report($sformatf("match_count %0d exp %0d", c, exp_count[0]));
      if (lst !== exp_last[0]) report($sformatf("last %0d exp %0d", lst, exp_last[0]));
      void'(exp_status.pop_front()); void'(exp_left.pop_front());
      void'(exp_right.pop_front()); void'(exp_count.pop_front());
      void'(exp_last.pop_front());
   endtask
endclass

module tb_top;
   import bmm_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [5:0] csr_wdata = 0;
   bmm_req_if req ();
   bmm_rsp_if rsp ();
   match_scoreboard sb = new();
   bit stim_done = 0;

   bipartite_max_matching dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req(req.sink), .rsp(rsp.source)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 0; req.cmd = 0; req.left_vertex = 0; req.right_vertex = 0;
      rsp.ready = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_result(rsp.status, rsp.pair_left, rsp.pair_right, rsp.match_count,
                         rsp.last);
   end

   initial begin
      int w;
      @(posedge clock iff !reset);
      forever begin
         w = $urandom_range(0, 4);
         if (w == 0 || $urandom_range(0, 3) == 0) rsp.ready <= 1;
         else begin
            rsp.ready <= 0;
            repeat (w) @(posedge clock);
            rsp.ready <= 1;
         end
         @(posedge clock iff rsp.valid);
      end
   end

   task automatic send_beat(logic cmd, logic [4:0] l, logic [4:0] r, bit gaps);
      int w;
      w = gaps ? $urandom_range(0, 4) : 0;
      if (w > 0) begin
         req.valid <= 0;
         repeat (w) @(posedge clock);
      end
      req.valid <= 1; req.cmd <= cmd; req.left_vertex <= l; req.right_vertex <= r;
      @(posedge clock iff req.ready);
      sb.note_input(cmd, l, r);
   endtask

   task automatic drain_and_idle();
      req.valid <= 0;
      @(posedge clock);
      while (sb.exp_status.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_vertices(logic [5:0] v);
      csr_we <= 1; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      sb.set_vertices(v);
   endtask

   task automatic random_graph(int n, int edges, bit gaps);
      for (int i = 0; i < edges; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_beat(CMD_ADD, 5'($urandom), 5'($urandom), gaps);
         else
            send_beat(CMD_ADD, 5'($urandom_range(0, n - 1)),
                      5'($urandom_range(0, n - 1)), gaps);
      end
      send_beat(CMD_RUN, 5'($urandom), 5'($urandom), gaps);
   endtask

   initial begin
      int n;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_beat(CMD_RUN, 5'd0, 5'd0, 1'b0);
      send_beat(CMD_ADD, 5'd0, 5'd31, 1'b0);
      send_beat(CMD_ADD, 5'd31, 5'd0, 1'b0);
      send_beat(CMD_ADD, 5'd31, 5'd31, 1'b0);
      send_beat(CMD_ADD, 5'd0, 5'd0, 1'b0);
      send_beat(CMD_ADD, 5'd1, 5'd0, 1'b0);
      send_beat(CMD_RUN, 5'd0, 5'd0, 1'b0);
      drain_and_idle();
      write_vertices(6'd0);
      send_beat(CMD_ADD, 5'd0, 5'd1, 1'b0);
      send_beat(CMD_ADD, 5'd0, 5'd0, 1'b0);
      send_beat(CMD_RUN, 5'd31, 5'd31, 1'b0);
      drain_and_idle();
      write_vertices(6'd4);
      send_beat(CMD_ADD, 5'd2, 5'd3, 1'b0);
      send_beat(CMD_ADD, 5'd4, 5'd1, 1'b0);
      send_beat(CMD_ADD, 5'd3, 5'd3, 1'b0);
      send_beat(CMD_ADD, 5'd1, 5'd2, 1'b0);
      drain_and_idle();
      write_vertices(6'd3);
      send_beat(CMD_RUN, 5'd0, 5'd0, 1'b0);
      drain_and_idle();
      write_vertices(6'd63);
      for (int ph = 0; ph < 6; ph++) begin
         n = (ph == 0) ? 32 : (ph == 1 ? 1 : $urandom_range(2, 31));
         write_vertices(6'(n));
         for (int g = 0; g < 3; g++) random_graph(n, $urandom_range(0, 10), 1'b1);
         drain_and_idle();
      end
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      if (sb.errors == 0 && sb.exp_status.size() == 0) $display("PASSED: all results match");
      else begin
         if (sb.exp_status.size() != 0) sb.report("expectations left over");
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

`default_nettype wire
